[hdl/cstok_pkg.sv]
package cstok_pkg;

	localparam int LEN_BITS = 32;
	localparam int VAL_BITS = 63;
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	typedef enum logic [2:0] {
		KIND_NUMBER  = 3'd0,
		KIND_IDENT   = 3'd1,
		KIND_KEYWORD = 3'd2,
		KIND_PUNCT   = 3'd3,
		KIND_END     = 3'd4,
		KIND_STRAY   = 3'd5,
		KIND_UNTERM  = 3'd6
	} kind_t;

	typedef struct packed {
		kind_t                 kind;
		logic [LEN_BITS-1:0]   start;
		logic [LEN_BITS-1:0]   len;
		logic [VAL_BITS-1:0]   value;
		logic                  last;
	} tok_t;

	// up to two results per source byte, in order r0 then r1
	typedef struct packed {
		logic [1:0] cnt;
		tok_t       r0;
		tok_t       r1;
	} tok_pair_t;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	// keyword spellings: int, return, void
	localparam logic [7:0] KW_CHR [3][8] = '{
		'{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
		'{"v", "o", "i", "d", 8'h00, 8'h00, 8'h00, 8'h00}
	};
	localparam logic [2:0] KW_LEN [3] = '{3'd3, 3'd6, 3'd4};

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic id_first(input logic [7:0] c);
		return is_alpha(c) || (c == "_");
	endfunction

	function automatic logic id_next(input logic [7:0] c);
		return is_alpha(c) || is_digit(c) || (c == "_");
	endfunction

	function automatic logic is_punct(input logic [7:0] c);
		return (c == "+") || (c == "-") || (c == "*") || (c == "/") || (c == "(") ||
			(c == ")") || (c == "{") || (c == "}") || (c == ";");
	endfunction

	// keywords still matching character c at index k
	function automatic logic [2:0] kw_hit(input logic [7:0] c, input logic [2:0] k);
		logic [2:0] hit;
		for (int i = 0; i < 3; i++) begin
			hit[i] = (k < KW_LEN[i]) && (KW_CHR[i][k] == c);
		end
		return hit;
	endfunction

endpackage

[hdl/cstok_core.sv]
module cstok_core import cstok_pkg::*; #(
	parameter int OFFSET_BITS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  logic [7:0]      c,
	input  logic            eos,
	output tok_pair_t       res
);

	typedef enum logic [7:0] {
		M_IDLE       = 8'b0000_0001,
		M_NUMBER     = 8'b0000_0010,
		M_IDENT      = 8'b0000_0100,
		M_SLASH      = 8'b0000_1000,
		M_LINE       = 8'b0001_0000,
		M_BLOCK      = 8'b0010_0000,
		M_BLOCK_STAR = 8'b0100_0000,
		M_ERROR      = 8'b1000_0000
	} mode_t;

	localparam logic [VAL_BITS-1:0] VALUE_MAX = '1;

	mode_t                  mode_q, mode_n;
	logic [OFFSET_BITS-1:0] pos_q, pos_n;
	logic [OFFSET_BITS-1:0] tstart_q, tstart_n;
	logic [VAL_BITS-1:0]    acc_q, acc_n;
	logic [2:0]             kw_q, kw_n;

	logic [OFFSET_BITS-1:0] span;
	logic [63:0]            span_w;
	logic [LEN_BITS-1:0]    len32;
	logic [2:0]             kidx;
	logic [3:0]             dig;
	logic [VAL_BITS+3:0]    prod;
	logic [VAL_BITS-1:0]    acc_step;

	logic                   pend_v;
	tok_t                   pend;
	logic                   idl_v;
	tok_t                   idl;
	mode_t                  idl_mode;
	logic                   idl_start;

	tok_t                   end_tok;
	logic                   do_pend, do_idle;
	logic                   push_p, push_i;

	assign span   = pos_q - tstart_q;
	assign span_w = 64'(span);
	assign len32  = (|span_w[63:LEN_BITS]) ? '1 : span_w[LEN_BITS-1:0];
	assign kidx   = (|span_w[63:3]) ? 3'd7 : span_w[2:0];
	assign dig    = 4'(c - CH_ZERO);

	// acc*10 + digit by shift and add; saturate on overflow
	assign prod     = (VAL_BITS+4)'({acc_q, 3'b000}) + (VAL_BITS+4)'({acc_q, 1'b0})
		+ (VAL_BITS+4)'(dig);
	assign acc_step = (|prod[VAL_BITS+3:VAL_BITS]) ? VALUE_MAX : prod[VAL_BITS-1:0];

	// token held open in the current mode
	always_comb begin
		pend_v      = 1'b1;
		pend.kind   = KIND_NUMBER;
		pend.start  = 32'(tstart_q);
		pend.len    = len32;
		pend.value  = '0;
		pend.last   = 1'b0;
		case (mode_q)
			M_NUMBER: begin
				pend.value = acc_q;
			end
			M_IDENT: begin
				if (kw_q[0] && len32 == 32'(KW_LEN[0])) begin
					pend.kind  = KIND_KEYWORD;
					pend.value = 63'd0;
				end else if (kw_q[1] && len32 == 32'(KW_LEN[1])) begin
					pend.kind  = KIND_KEYWORD;
					pend.value = 63'd1;
				end else if (kw_q[2] && len32 == 32'(KW_LEN[2])) begin
					pend.kind  = KIND_KEYWORD;
					pend.value = 63'd2;
				end else begin
					pend.kind  = KIND_IDENT;
				end
			end
			M_SLASH: begin
				pend.kind  = KIND_PUNCT;
				pend.len   = 32'd1;
				pend.value = 63'(CH_SLASH);
			end
			M_BLOCK, M_BLOCK_STAR: begin
				pend.kind = KIND_UNTERM;
			end
			default: begin
				pend_v = 1'b0;
			end
		endcase
	end

	// byte seen from idle
	always_comb begin
		idl_v      = 1'b0;
		idl_mode   = M_IDLE;
		idl_start  = 1'b0;
		idl.kind   = KIND_PUNCT;
		idl.start  = 32'(pos_q);
		idl.len    = 32'd1;
		idl.value  = 63'(c);
		idl.last   = 1'b0;
		if (is_space(c)) begin
			idl_mode = M_IDLE;
		end else if (c == CH_SLASH) begin
			idl_mode  = M_SLASH;
			idl_start = 1'b1;
		end else if (is_digit(c)) begin
			idl_mode  = M_NUMBER;
			idl_start = 1'b1;
		end else if (id_first(c)) begin
			idl_mode  = M_IDENT;
			idl_start = 1'b1;
		end else if (is_punct(c)) begin
			idl_v = 1'b1;
		end else begin
			idl_v    = 1'b1;
			idl.kind = KIND_STRAY;
			idl_mode = M_ERROR;
		end
	end

	always_comb begin
		end_tok.kind  = KIND_END;
		end_tok.start = 32'(pos_q);
		end_tok.len   = '0;
		end_tok.value = '0;
		end_tok.last  = 1'b1;
	end

	always_comb begin
		mode_n   = mode_q;
		tstart_n = tstart_q;
		acc_n    = acc_q;
		kw_n     = kw_q;
		pos_n    = (pos_q != '1) ? pos_q + 1'b1 : pos_q;
		do_pend  = 1'b0;
		do_idle  = 1'b0;
		push_p   = 1'b0;
		push_i   = 1'b0;
		res      = '0;

		if (eos) begin
			mode_n   = M_IDLE;
			pos_n    = '0;
			tstart_n = '0;
			acc_n    = '0;
			kw_n     = 3'b111;
			if (pend_v) begin
				res.cnt = 2'd2;
				res.r0  = pend;
				res.r1  = end_tok;
			end else begin
				res.cnt = 2'd1;
				res.r0  = end_tok;
			end
		end else begin
			case (mode_q)
				M_ERROR: begin
				end
				M_LINE: begin
					if (c == CH_LF) mode_n = M_IDLE;
				end
				M_BLOCK: begin
					if (c == CH_STAR) mode_n = M_BLOCK_STAR;
				end
				M_BLOCK_STAR: begin
					if (c == CH_SLASH) begin
						mode_n = M_IDLE;
					end else if (c != CH_STAR) begin
						mode_n = M_BLOCK;
					end
				end
				M_SLASH: begin
					if (c == CH_SLASH) begin
						mode_n = M_LINE;
					end else if (c == CH_STAR) begin
						mode_n = M_BLOCK;
					end else begin
						do_pend = 1'b1;
						do_idle = 1'b1;
					end
				end
				M_NUMBER: begin
					if (is_digit(c)) begin
						acc_n = acc_step;
					end else begin
						do_pend = 1'b1;
						do_idle = 1'b1;
					end
				end
				M_IDENT: begin
					if (id_next(c)) begin
						kw_n = kw_q & kw_hit(c, kidx);
					end else begin
						do_pend = 1'b1;
						do_idle = 1'b1;
					end
				end
				default: begin
					do_idle = 1'b1;
				end
			endcase

			if (do_idle) begin
				mode_n = idl_mode;
				if (idl_start) tstart_n = pos_q;
				if (idl_mode == M_NUMBER) acc_n = 63'(dig);
				if (idl_mode == M_IDENT) kw_n = kw_hit(c, 3'd0);
			end

			push_p = do_pend && pend_v;
			push_i = do_idle && idl_v;
			if (push_p) begin
				res.r0 = pend;
				if (push_i) begin
					res.r1      = idl;
					res.r1.last = 1'b1;
					res.cnt     = 2'd2;
				end else begin
					res.r0.last = 1'b1;
					res.cnt     = 2'd1;
				end
			end else if (push_i) begin
				res.r0      = idl;
				res.r0.last = 1'b1;
				res.cnt     = 2'd1;
			end
		end

		if (!fire) res.cnt = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			pos_q    <= '0;
			tstart_q <= '0;
			acc_q    <= '0;
			kw_q     <= 3'b111;
		end else if (fire) begin
			mode_q   <= mode_n;
			pos_q    <= pos_n;
			tstart_q <= tstart_n;
			acc_q    <= acc_n;
			kw_q     <= kw_n;
		end
	end

endmodule

[hdl/cstok_rfifo.sv]
module cstok_rfifo import cstok_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  tok_pair_t push,
	input  logic      pop,
	output logic      has_room,
	output logic      head_valid,
	output tok_t      head
);

	tok_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] rd_q, wr_q, wr_next;
	logic [QCNT_W-1:0] count_q;

	assign wr_next    = wr_q + 1'b1;
	assign has_room   = count_q <= QCNT_W'(QDEPTH - 2);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) mem_q[wr_q] <= push.r0;
		if (push.cnt == 2'd2) mem_q[wr_next] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q    <= '0;
			wr_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + QPTR_W'(push.cnt);
			if (pop) rd_q <= rd_q + 1'b1;
			count_q <= count_q + QCNT_W'(push.cnt) - QCNT_W'(pop);
		end
	end

endmodule

[hdl/c_subset_tokenizer_unit.sv]
// channel   | direction | fields                                        | handshake
// source    | in        | source_byte, end_of_source                    | src_valid / src_stall
// token     | out       | token_kind, start_offset, token_length,       | tok_valid / tok_stall
//           |           | token_value, last_of_run                      |
//
// One request per cycle enters the input register while src_stall is low; the core decodes
// it from that register and writes its results into a four-entry result queue. The first
// result reaches the token port once written into the queue. A request giving one result
// keeps a rate of one per cycle while neither port stalls; an end marker after an open
// token, or a byte that ends a token and starts another result, gives two, which leave
// one at a time through the single queue read port. Reset clears scan state and empties
// the queue. src_stall rises when a request waits and the queue lacks room for two
// results, so a stalled output backs up into the source once the queue fills.
module c_subset_tokenizer_unit import cstok_pkg::*; #(
	parameter int OFFSET_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_stall,
	input  logic [7:0]          source_byte,
	input  logic                end_of_source,
	output logic                tok_valid,
	input  logic                tok_stall,
	output logic [2:0]          token_kind,
	output logic [LEN_BITS-1:0] start_offset,
	output logic [LEN_BITS-1:0] token_length,
	output logic [VAL_BITS-1:0] token_value,
	output logic                last_of_run
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eos_s1;
	logic       fire_s1;
	logic       has_room;
	tok_pair_t  res;
	tok_t       head;

	assign fire_s1   = valid_s1 && has_room;
	assign src_stall = valid_s1 && !has_room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!src_stall) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			byte_s1 <= source_byte;
			eos_s1  <= end_of_source;
		end
	end

	cstok_core #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire_s1),
		.c      (byte_s1),
		.eos    (eos_s1),
		.res    (res)
	);

	cstok_rfifo u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (res),
		.pop        (tok_valid && !tok_stall),
		.has_room   (has_room),
		.head_valid (tok_valid),
		.head       (head)
	);

	assign token_kind   = head.kind;
	assign start_offset = head.start;
	assign token_length = head.len;
	assign token_value  = head.value;
	assign last_of_run  = head.last;

endmodule

[hdl/cstok_chk.sv]
module cstok_chk import cstok_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                src_valid,
	input logic                src_stall,
	input logic [7:0]          source_byte,
	input logic                end_of_source,
	input logic                tok_valid,
	input logic                tok_stall,
	input logic [2:0]          token_kind,
	input logic [LEN_BITS-1:0] start_offset,
	input logic [LEN_BITS-1:0] token_length,
	input logic [VAL_BITS-1:0] token_value,
	input logic                last_of_run
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_stall |=> tok_valid && $stable(token_kind) &&
		$stable(start_offset) && $stable(token_length) && $stable(token_value) &&
		$stable(last_of_run))
		else $error("stalled result changed");

	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && token_kind == KIND_END |->
		last_of_run && token_length == '0 && token_value == '0)
		else $error("end token malformed");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && (token_kind == KIND_PUNCT || token_kind == KIND_STRAY) |->
		token_length == 32'd1)
		else $error("single-character result with wrong length");

	a_keyword: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && token_kind == KIND_KEYWORD |->
		(token_value == 63'd0 && token_length == 32'd3) ||
		(token_value == 63'd1 && token_length == 32'd6) ||
		(token_value == 63'd2 && token_length == 32'd4))
		else $error("keyword index and length disagree");

endmodule

bind c_subset_tokenizer_unit cstok_chk u_chk (.*);

[dv/tb_c_subset_tokenizer_unit.sv]
module tb_c_subset_tokenizer_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import cstok_pkg::*;

	typedef enum logic [2:0] {
		SCAN_IDLE,
		SCAN_NUMBER,
		SCAN_WORD,
		SCAN_SLASH,
		SCAN_LINE_CMT,
		SCAN_BLOCK_CMT,
		SCAN_BLOCK_STAR,
		SCAN_SKIP
	} scan_mode_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       eos;
	} src_req_t;

	localparam logic [63:0] VALUE_CEIL = 64'h7FFF_FFFF_FFFF_FFFF;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                src_valid = 1'b0;
	logic                src_stall;
	logic [7:0]          source_byte = 8'h00;
	logic                end_of_source = 1'b0;
	logic                tok_valid;
	logic                tok_stall = 1'b0;
	logic [2:0]          token_kind;
	logic [LEN_BITS-1:0] start_offset;
	logic [LEN_BITS-1:0] token_length;
	logic [VAL_BITS-1:0] token_value;
	logic                last_of_run;

	c_subset_tokenizer_unit uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// lexer state as the block should hold it
	scan_mode_t           mode = SCAN_IDLE;
	logic [31:0]          pos = '0;
	logic [31:0]          tok_at = '0;
	logic [VAL_BITS-1:0]  acc = '0;
	logic [2:0]           cands = 3'b111;
	string                kw_words[3] = '{"int", "return", "void"};

	src_req_t feed_q[$];
	tok_t     step_tokens[$];
	tok_t     tokens_due[$];

	int gap_pct = 0;
	int stall_pct = 0;
	int fed = 0;
	int taken = 0;
	int sources = 0;
	int checked = 0;
	int fails = 0;
	int kind_tally[8];

	function automatic tok_t mk_tok(kind_t k, logic [31:0] s, logic [31:0] l,
			logic [VAL_BITS-1:0] v);
		tok_t t;
		t.kind  = k;
		t.start = s;
		t.len   = l;
		t.value = v;
		t.last  = 1'b0;
		return t;
	endfunction

	function automatic logic is_dec(logic [7:0] c);
		return c inside {["0":"9"]};
	endfunction

	task automatic narrow_kw(logic [7:0] c);
		int k;
		k = pos - tok_at;
		for (int i = 0; i < 3; i++) begin
			if (k >= kw_words[i].len() || kw_words[i][k] != c)
				cands[i] = 1'b0;
		end
	endtask

	// emit whatever token is still open
	task automatic close_token();
		logic [31:0] span;
		int hit;
		span = pos - tok_at;
		hit = 0;
		case (mode)
		SCAN_NUMBER: step_tokens.push_back(mk_tok(KIND_NUMBER, tok_at, span, acc));
		SCAN_WORD: begin
			// lowest keyword index wins
			for (int i = 2; i >= 0; i--) begin
				if (cands[i] && span == kw_words[i].len())
					hit = i + 1;
			end
			if (hit != 0)
				step_tokens.push_back(mk_tok(KIND_KEYWORD, tok_at, span, hit - 1));
			else
				step_tokens.push_back(mk_tok(KIND_IDENT, tok_at, span, '0));
		end
		SCAN_SLASH: step_tokens.push_back(mk_tok(KIND_PUNCT, tok_at, 1, "/"));
		SCAN_BLOCK_CMT, SCAN_BLOCK_STAR:
			step_tokens.push_back(mk_tok(KIND_UNTERM, tok_at, span, '0));
		default: ;
		endcase
	endtask

	task automatic open_token(logic [7:0] c);
		mode = SCAN_IDLE;
		if (c inside {8'h20, [8'h09:8'h0D]}) begin
		end else if (c == "/") begin
			mode = SCAN_SLASH;
			tok_at = pos;
		end else if (is_dec(c)) begin
			mode = SCAN_NUMBER;
			tok_at = pos;
			acc = c - "0";
		end else if (c inside {["a":"z"], ["A":"Z"], "_"}) begin
			mode = SCAN_WORD;
			tok_at = pos;
			cands = 3'b111;
			narrow_kw(c);
		end else if (c inside {"+", "-", "*", "(", ")", "{", "}", ";"}) begin
			step_tokens.push_back(mk_tok(KIND_PUNCT, pos, 1, c));
		end else begin
			step_tokens.push_back(mk_tok(KIND_STRAY, pos, 1, c));
			mode = SCAN_SKIP;
		end
	endtask

	// advance the lexer by one accepted request and queue its tokens
	task automatic lex_accept(logic [7:0] c, logic eos);
		logic [63:0] d;
		step_tokens.delete();
		if (eos) begin
			close_token();
			step_tokens.push_back(mk_tok(KIND_END, pos, 0, '0));
			mode = SCAN_IDLE;
			pos = '0;
			tok_at = '0;
			acc = '0;
			cands = 3'b111;
		end else begin
			case (mode)
			SCAN_SKIP: ;
			SCAN_LINE_CMT: if (c == 8'h0A) mode = SCAN_IDLE;
			SCAN_BLOCK_CMT: if (c == "*") mode = SCAN_BLOCK_STAR;
			SCAN_BLOCK_STAR: begin
				if (c == "/")
					mode = SCAN_IDLE;
				else if (c != "*")
					mode = SCAN_BLOCK_CMT;
			end
			SCAN_SLASH: begin
				if (c == "/")
					mode = SCAN_LINE_CMT;
				else if (c == "*")
					mode = SCAN_BLOCK_CMT;
				else begin
					close_token();
					open_token(c);
				end
			end
			SCAN_NUMBER: begin
				if (is_dec(c)) begin
					d = c - "0";
					if ({1'b0, acc} > (VALUE_CEIL - d) / 10)
						acc = VALUE_CEIL[VAL_BITS-1:0];
					else
						acc = acc * 10 + d[VAL_BITS-1:0];
				end else begin
					close_token();
					open_token(c);
				end
			end
			SCAN_WORD: begin
				if (c inside {["a":"z"], ["A":"Z"], ["0":"9"], "_"})
					narrow_kw(c);
				else begin
					close_token();
					open_token(c);
				end
			end
			default: open_token(c);
			endcase
			if (pos != '1)
				pos++;
		end
		if (step_tokens.size() != 0)
			step_tokens[step_tokens.size() - 1].last = 1'b1;
		foreach (step_tokens[i])
			tokens_due.push_back(step_tokens[i]);
	endtask

	// request driver: hold the payload while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
			source_byte <= 8'h00;
			end_of_source <= 1'b0;
		end else begin
			if (src_valid && !src_stall) begin
				lex_accept(source_byte, end_of_source);
				taken++;
			end
			if (!src_valid || !src_stall) begin
				if (feed_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
					{source_byte, end_of_source} <= feed_q.pop_front();
					src_valid <= 1'b1;
				end else begin
					src_valid <= 1'b0;
				end
			end
		end
	end

	// token monitor and output stall
	always @(posedge clk or negedge arst_n) begin
		tok_t want;
		if (!arst_n) begin
			tok_stall <= 1'b0;
		end else begin
			if (tok_valid && !tok_stall) begin
				checked++;
				kind_tally[token_kind]++;
				if (tokens_due.size() == 0) begin
					if (fails < 10)
						$display("%0t: token with none pending: kind %0d start %0d len %0d",
							$time, token_kind, start_offset, token_length);
					fails++;
				end else begin
					want = tokens_due.pop_front();
					if (token_kind !== want.kind || start_offset !== want.start ||
							token_length !== want.len || token_value !== want.value ||
							last_of_run !== want.last) begin
						if (fails < 10)
							$display({"%0t: token mismatch (expected/actual): kind %0d/%0d",
								" start %0d/%0d len %0d/%0d value %0d/%0d last %0b/%0b"},
								$time, want.kind, token_kind, want.start, start_offset,
								want.len, token_length, want.value, token_value,
								want.last, last_of_run);
						fails++;
					end
				end
			end
			tok_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic put_byte(logic [7:0] c);
		feed_q.push_back('{ch: c, eos: 1'b0});
		fed++;
	endtask

	task automatic put_text(string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endtask

	task automatic put_end();
		feed_q.push_back('{ch: 8'($urandom), eos: 1'b1});
		fed++;
		sources++;
	endtask

	task automatic put_blank();
		int pick;
		pick = $urandom_range(5);
		put_byte(pick == 5 ? 8'h20 : 8'(8'h09 + pick));
	endtask

	function automatic logic [7:0] filler(bit in_line);
		logic [7:0] c;
		case ($urandom_range(5))
		0, 1: c = "*";
		2: c = "/";
		default: c = 8'($urandom_range(1, 255));
		endcase
		if (in_line && c == 8'h0A)
			c = "x";
		return c;
	endfunction

	// one source of mostly well-formed tokens, some noise, then the end marker
	task automatic gen_source();
		string word_bank[12] = '{"int", "return", "void", "in", "retur", "voi", "ints",
			"returned", "void_", "i", "r", "v"};
		string ops = "+-*/(){};";
		int pick;
		int n;
		n = $urandom_range(1, 12);
		repeat (n) begin
			if ($urandom_range(9) < 6)
				repeat ($urandom_range(1, 3)) put_blank();
			pick = $urandom_range(99);
			if (pick < 25) begin
				case ($urandom_range(9))
				0: put_text($urandom_range(1) ? "9223372036854775807" : "9223372036854775808");
				1: repeat ($urandom_range(18, 22)) put_byte(8'("0" + $urandom_range(9)));
				default: repeat ($urandom_range(1, 5)) put_byte(8'("0" + $urandom_range(9)));
				endcase
			end else if (pick < 50) begin
				if ($urandom_range(9) < 4) begin
					put_text(word_bank[$urandom_range(11)]);
				end else begin
					n = $urandom_range(1, 6);
					for (int i = 0; i < n; i++) begin
						pick = $urandom_range(i == 0 ? 52 : 62);
						put_byte(pick < 26 ? 8'("a" + pick) : pick < 52 ? 8'("A" + pick - 26) :
							pick == 52 ? "_" : 8'("0" + pick - 53));
					end
				end
			end else if (pick < 70) begin
				put_byte(ops[$urandom_range(8)]);
			end else if (pick < 78) begin
				put_text("//");
				repeat ($urandom_range(0, 6)) put_byte(filler(1'b1));
				put_byte(8'h0A);
			end else if (pick < 90) begin
				put_text("/*");
				repeat ($urandom_range(0, 6)) put_byte(filler(1'b0));
				put_text($urandom_range(2) != 0 ? "*/" : "**/");
			end else if (pick < 97) begin
				repeat ($urandom_range(1, 4)) put_blank();
			end else begin
				put_byte(8'($urandom_range(1, 255)));
			end
		end
		pick = $urandom_range(19);
		if (pick == 0) begin
			put_text("/*");
			repeat ($urandom_range(0, 4)) put_byte(filler(1'b0));
		end else if (pick == 1) begin
			put_byte("/");
		end
		put_end();
	endtask

	initial begin
		int goal;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
			0: begin gap_pct = 0;  stall_pct = 0;  end
			1: begin gap_pct = 88; stall_pct = 0;  end
			2: begin gap_pct = 0;  stall_pct = 88; end
			default: begin gap_pct = 9; stall_pct = 9; end
			endcase
			if (phase == 0) begin
				// keyword cut by a slash, lone slash flushed by an identifier
				put_text("int/x");
				put_end();
				// keyword then punct in one step, line comment, slash-star-slash left open
				put_text("void-//\n*/*/");
				put_end();
				// keyword ended by a high stray byte, rest ignored
				put_text("return");
				put_byte(8'hFF);
				put_byte(8'h01);
				put_end();
				put_byte(8'h00);
				put_byte(";");
				put_end();
			end
			goal = fed + 300;
			while (fed < goal)
				gen_source();
			// hold the next phase until every token is back
			do @(negedge clk); while (taken != fed || tokens_due.size() != 0);
		end
		repeat (20) @(negedge clk);
		fails += tokens_due.size();
		$display("Drove %0d requests in %0d sources; checked %0d tokens, %0d failures.",
			fed, sources, checked, fails);
		$display({"Kinds: number %0d ident %0d keyword %0d punct %0d end %0d",
			" stray %0d open comment %0d"}, kind_tally[0], kind_tally[1], kind_tally[2],
			kind_tally[3], kind_tally[4], kind_tally[5], kind_tally[6]);
		if (fails == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timeout: %0d of %0d requests taken, %0d tokens pending",
			taken, fed, tokens_due.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule

[filelist.f]
hdl/cstok_pkg.sv
hdl/cstok_core.sv
hdl/cstok_rfifo.sv
hdl/c_subset_tokenizer_unit.sv
hdl/cstok_chk.sv
dv/tb_c_subset_tokenizer_unit.sv
